// ----- rtl/avs_pkg.sv -----
// Shared types, codes and helpers for the ATA read-verify sweep sequencer.
package avs_pkg;

  localparam int SECTOR_BITS_DEF = 48;

  // Input function codes
  localparam logic [1:0] FUNC_RESTART  = 2'd0;
  localparam logic [1:0] FUNC_ISSUE    = 2'd1;
  localparam logic [1:0] FUNC_COMPLETE = 2'd2;

  // Addressing and length modes
  localparam logic [3:0] MODE_CHS      = 4'd0;
  localparam logic [3:0] MODE_LBA      = 4'd1;
  localparam logic [3:0] MODE_LBA48    = 4'd2;
  localparam logic [3:0] MODE_CHS7     = 4'd3;
  localparam logic [3:0] MODE_CHSTRK   = 4'd4;
  localparam logic [3:0] MODE_LBA7     = 4'd5;
  localparam logic [3:0] MODE_LBA63    = 4'd6;
  localparam logic [3:0] MODE_LBA48X7  = 4'd7;
  localparam logic [3:0] MODE_LBA48X63 = 4'd8;

  // Configuration register indexes
  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_DRIVE = 3'd1;
  localparam logic [2:0] CFG_CYL   = 3'd2;
  localparam logic [2:0] CFG_HEADS = 3'd3;
  localparam logic [2:0] CFG_SPT   = 3'd4;

  // Task-file register offsets
  localparam logic [2:0] TF_FEATURES = 3'd1;
  localparam logic [2:0] TF_COUNT    = 3'd2;
  localparam logic [2:0] TF_LBA_LO   = 3'd3;
  localparam logic [2:0] TF_LBA_MID  = 3'd4;
  localparam logic [2:0] TF_LBA_HI   = 3'd5;
  localparam logic [2:0] TF_DEVICE   = 3'd6;
  localparam logic [2:0] TF_COMMAND  = 3'd7;

  localparam logic [7:0] CMD_VERIFY     = 8'h40;
  localparam logic [7:0] CMD_VERIFY_EXT = 8'h42;
  localparam logic [7:0] DEV_CHS        = 8'hA0;
  localparam logic [7:0] DEV_LBA        = 8'hE0;
  localparam logic [7:0] DEV_LBA48      = 8'h40;

  localparam logic [3:0] RUN_SHORT = 4'd7;
  localparam logic [3:0] RUN_LONG  = 4'd11;

  typedef struct packed {
    logic [3:0]  mode;
    logic        drive;
    logic [15:0] cylinders;
    logic [7:0]  heads;
    logic [7:0]  spt;
  } cfg_t;

  typedef struct packed {
    logic       restart;
    logic       complete;
    logic       div_start;
    logic       div_sel;
    logic       calc_len;
    logic       load_out;
    logic       refused;
    logic [3:0] idx;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic refuse;
    logic chs;
    logic wide;
    logic out_free;
  } stat_t;

  function automatic logic [3:0] eff_mode(input logic [3:0] m);
    return (m > MODE_LBA48X63) ? MODE_LBA : m;
  endfunction

  function automatic logic is_chs(input logic [3:0] m);
    logic [3:0] e;
    e = eff_mode(m);
    return (e == MODE_CHS) || (e == MODE_CHS7) || (e == MODE_CHSTRK);
  endfunction

  function automatic logic is_wide(input logic [3:0] m);
    logic [3:0] e;
    e = eff_mode(m);
    return (e == MODE_LBA48) || (e == MODE_LBA48X7) || (e == MODE_LBA48X63);
  endfunction

endpackage

// ----- rtl/avs_div.sv -----
// Restoring divider: W-bit dividend by 8-bit divisor, one quotient bit per cycle.
module avs_div import avs_pkg::*; #(
  parameter int W = SECTOR_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [7:0]   divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [7:0]   rem
);
  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [8:0]    trial;
  logic          fits;

  assign trial = {rem_r, quo_r[W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      quo_nxt  = dividend;
      rem_nxt  = 8'd0;
    end else if (busy_r) begin
      rem_nxt = fits ? 8'(trial - {1'b0, divisor}) : trial[7:0];
      quo_nxt = {quo_r[W-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;
endmodule

// ----- rtl/avs_ctrl.sv -----
// Sequencer state machine: accepts items, runs the divisions, paces the write run.
module avs_ctrl import avs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  stat_t      stat,
  output cmd_t       cmd
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV1 = 5'b00010,
    S_DIV2 = 5'b00100,
    S_LEN  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       refused_r, refused_nxt;
  logic [3:0] run_len;
  logic       acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign run_len  = refused_r ? 4'd1 : (stat.wide ? RUN_LONG : RUN_SHORT);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    refused_nxt = refused_r;
    cmd         = '0;
    cmd.idx     = idx_r;
    cmd.refused = refused_r;
    cmd.last    = (idx_r == run_len - 4'd1);
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_func)
            FUNC_RESTART:  cmd.restart  = 1'b1;
            FUNC_COMPLETE: cmd.complete = 1'b1;
            FUNC_ISSUE: begin
              idx_nxt = 4'd0;
              if (stat.refuse) begin
                refused_nxt = 1'b1;
                state_nxt   = S_EMIT;
              end else if (stat.chs) begin
                refused_nxt   = 1'b0;
                cmd.div_start = 1'b1;
                state_nxt     = S_DIV1;
              end else begin
                refused_nxt = 1'b0;
                state_nxt   = S_LEN;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          // chain quotient straight into the head/cylinder split
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_sel = 1'b1;
        if (stat.div_done) state_nxt = S_LEN;
      end
      S_LEN: begin
        cmd.calc_len = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          idx_nxt      = idx_r + 4'd1;
          if (cmd.last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= 4'd0;
      refused_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      refused_r <= refused_nxt;
    end
  end
endmodule

// ----- rtl/avs_dp.sv -----
// Datapath: sector cursor, CHS conversion, length sizing and result register.
module avs_dp import avs_pkg::*; #(
  parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic [7:0] in_status,
  input  cmd_t       cmd,
  output stat_t      stat,
  input  logic       out_ready,
  output logic       out_valid,
  output logic       out_write_valid,
  output logic [2:0] out_reg_offset,
  output logic [7:0] out_reg_value,
  output logic       out_last,
  output logic       out_stopped,
  output logic [5:0] out_sectors_in_command
);
  localparam int SB = SECTOR_BITS;
  localparam logic [63:0] B24 = 64'h1000000;
  localparam logic [63:0] B28 = 64'h10000000;
  localparam logic [63:0] B32 = 64'h100000000;
  localparam logic [63:0] LOW24 = 64'hFFFFFF;

  logic [SB-1:0] cursor_r, cursor_nxt;
  logic          halted_r, halted_nxt;
  logic [5:0]    last_len_r, last_len_nxt;
  logic [7:0]    sectn_r, head_r;
  logic [15:0]   cyl_r;
  logic [5:0]    len_r;

  logic          div_done;
  logic [SB-1:0] div_q;
  logic [7:0]    div_rem;
  logic [SB-1:0] div_a;
  logic [7:0]    div_b;
  logic [63:0]   s64, jump;
  logic [3:0]    em;
  logic [8:0]    span;
  logic [5:0]    len_calc;

  assign em    = eff_mode(cfg.mode);
  assign s64   = 64'(cursor_r);
  assign div_a = cmd.div_sel ? div_q : cursor_r;
  assign div_b = cmd.div_sel ? cfg.heads : cfg.spt;

  avs_div #(.W(SB)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  assign stat.div_done = div_done;
  assign stat.chs      = is_chs(cfg.mode);
  assign stat.wide     = is_wide(cfg.mode);
  assign stat.refuse   = halted_r || (is_chs(cfg.mode) &&
                         (cfg.cylinders == 16'd0 || cfg.heads == 8'd0 || cfg.spt == 8'd0));
  assign stat.out_free = !out_valid || out_ready;

  // sectors left on the track from the current sector
  assign span = {1'b0, cfg.spt} - {1'b0, sectn_r} + 9'd1;

  always_comb begin
    case (em)
      MODE_CHS7:     len_calc = (span < 9'd7) ? span[5:0] : 6'd7;
      MODE_CHSTRK:   len_calc = (span > 9'd63) ? 6'd63 : span[5:0];
      MODE_LBA7, MODE_LBA48X7:   len_calc = 6'd7;
      MODE_LBA63, MODE_LBA48X63: len_calc = 6'd63;
      default:       len_calc = 6'd1;
    endcase
  end

  // LBA48 single-sector mode hops across the 24/28/32-bit boundaries
  always_comb begin
    if (s64 < B24)      jump = s64 + B24;
    else if (s64 < B28) jump = s64 + (B28 - B24);
    else if (s64 < B32) jump = s64 + (B32 - B28);
    else                jump = s64 + 64'd1 - B32;
  end

  always_comb begin
    cursor_nxt   = cursor_r;
    halted_nxt   = halted_r;
    last_len_nxt = last_len_r;
    if (cmd.restart) begin
      cursor_nxt   = '0;
      halted_nxt   = 1'b0;
      last_len_nxt = 6'd1;
    end else if (cmd.complete && !halted_r) begin
      if (in_status[0]) halted_nxt = 1'b1;
      else if (em == MODE_LBA48 && (s64 & LOW24) == 64'd0) cursor_nxt = jump[SB-1:0];
      else cursor_nxt = cursor_r + SB'(last_len_r);
    end else if (cmd.calc_len) begin
      last_len_nxt = len_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r   <= '0;
      halted_r   <= 1'b0;
      last_len_r <= 6'd1;
    end else begin
      cursor_r   <= cursor_nxt;
      halted_r   <= halted_nxt;
      last_len_r <= last_len_nxt;
    end
    // the first division finishes as the second one is started
    if (div_done && cmd.div_start) sectn_r <= div_rem + 8'd1;
    if (div_done && cmd.div_sel && !cmd.div_start) begin
      head_r <= div_rem;
      cyl_r  <= div_q[15:0];
    end
    if (cmd.calc_len) len_r <= len_calc;
  end

  logic [2:0] e_off;
  logic [7:0] e_val;
  logic [7:0] drv;
  assign drv = {3'd0, cfg.drive, 4'd0};

  always_comb begin
    e_off = 3'd0;
    e_val = 8'd0;
    if (stat.chs) begin
      case (cmd.idx)
        4'd0: begin e_off = TF_DEVICE;   e_val = DEV_CHS | drv | {4'd0, head_r[3:0]}; end
        4'd1: begin e_off = TF_FEATURES; e_val = 8'd0; end
        4'd2: begin e_off = TF_COUNT;    e_val = {2'd0, len_r}; end
        4'd3: begin e_off = TF_LBA_LO;   e_val = sectn_r; end
        4'd4: begin e_off = TF_LBA_MID;  e_val = cyl_r[7:0]; end
        4'd5: begin e_off = TF_LBA_HI;   e_val = cyl_r[15:8]; end
        default: begin e_off = TF_COMMAND; e_val = CMD_VERIFY; end
      endcase
    end else if (stat.wide) begin
      case (cmd.idx)
        4'd0: begin e_off = TF_DEVICE;   e_val = DEV_LBA48 | drv; end
        4'd1: begin e_off = TF_FEATURES; e_val = 8'd0; end
        4'd2: begin e_off = TF_COUNT;    e_val = 8'd0; end
        4'd3: begin e_off = TF_LBA_LO;   e_val = s64[31:24]; end
        4'd4: begin e_off = TF_LBA_MID;  e_val = s64[39:32]; end
        4'd5: begin e_off = TF_LBA_HI;   e_val = s64[47:40]; end
        4'd6: begin e_off = TF_COUNT;    e_val = {2'd0, len_r}; end
        4'd7: begin e_off = TF_LBA_LO;   e_val = s64[7:0]; end
        4'd8: begin e_off = TF_LBA_MID;  e_val = s64[15:8]; end
        4'd9: begin e_off = TF_LBA_HI;   e_val = s64[23:16]; end
        default: begin e_off = TF_COMMAND; e_val = CMD_VERIFY_EXT; end
      endcase
    end else begin
      case (cmd.idx)
        4'd0: begin e_off = TF_DEVICE;   e_val = DEV_LBA | drv | {4'd0, s64[27:24]}; end
        4'd1: begin e_off = TF_FEATURES; e_val = 8'd0; end
        4'd2: begin e_off = TF_COUNT;    e_val = {2'd0, len_r}; end
        4'd3: begin e_off = TF_LBA_LO;   e_val = s64[7:0]; end
        4'd4: begin e_off = TF_LBA_MID;  e_val = s64[15:8]; end
        4'd5: begin e_off = TF_LBA_HI;   e_val = s64[23:16]; end
        default: begin e_off = TF_COMMAND; e_val = CMD_VERIFY; end
      endcase
    end
  end

  logic out_valid_r, out_valid_nxt;
  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (cmd.load_out) begin
      out_write_valid        <= !cmd.refused;
      out_reg_offset         <= cmd.refused ? 3'd0 : e_off;
      out_reg_value          <= cmd.refused ? 8'd0 : e_val;
      out_last               <= cmd.last;
      out_stopped            <= cmd.refused;
      out_sectors_in_command <= cmd.refused ? 6'd0 : len_r;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// ----- rtl/ata_verify_sweep_taskfile_gen_unit.sv -----
// Top level of the ATA read-verify sweep sequencer with its APB register file.
// Restart, completion and unused items act in idle; an LBA issue sizes its length,
// then emits 7 or 11 results; a refused issue emits one closing result; a CHS issue
// first runs two serial divisions on the divider, one quotient bit per cycle.
// One item is in flight at a time; the next is taken once its last result is loaded.
// Synchronous active-low reset clears cursor, halt flag and config registers; last length reads 1.
module ata_verify_sweep_taskfile_gen_unit import avs_pkg::*; #(
  parameter int SECTOR_BITS = SECTOR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_valid,
  output logic [2:0]  out_reg_offset,
  output logic [7:0]  out_reg_value,
  output logic        out_last,
  output logic        out_stopped,
  output logic [5:0]  out_sectors_in_command,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t  cfg_r, cfg_nxt;
  cmd_t  cmd;
  stat_t stat;
  logic  wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (paddr[4:2])
        CFG_MODE:  cfg_nxt.mode      = pwdata[3:0];
        CFG_DRIVE: cfg_nxt.drive     = pwdata[0];
        CFG_CYL:   cfg_nxt.cylinders = pwdata[15:0];
        CFG_HEADS: cfg_nxt.heads     = pwdata[7:0];
        CFG_SPT:   cfg_nxt.spt       = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      CFG_MODE:  prdata = {28'd0, cfg_r.mode};
      CFG_DRIVE: prdata = {31'd0, cfg_r.drive};
      CFG_CYL:   prdata = {16'd0, cfg_r.cylinders};
      CFG_HEADS: prdata = {24'd0, cfg_r.heads};
      CFG_SPT:   prdata = {24'd0, cfg_r.spt};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else        cfg_r <= cfg_nxt;
  end

  avs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .stat     (stat),
    .cmd      (cmd)
  );

  avs_dp #(.SECTOR_BITS(SECTOR_BITS)) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .in_status              (in_status),
    .cmd                    (cmd),
    .stat                   (stat),
    .out_ready              (out_ready),
    .out_valid              (out_valid),
    .out_write_valid        (out_write_valid),
    .out_reg_offset         (out_reg_offset),
    .out_reg_value          (out_reg_value),
    .out_last               (out_last),
    .out_stopped            (out_stopped),
    .out_sectors_in_command (out_sectors_in_command)
  );
endmodule

// ----- rtl/avs_checker.sv -----
// Port-level checks for the sweep sequencer, bound to the top level.
module avs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_write_valid,
  input logic [2:0] out_reg_offset,
  input logic [7:0] out_reg_value,
  input logic       out_last,
  input logic       out_stopped
);
  localparam logic [2:0] OFF_COMMAND = 3'd7;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reg_value) && $stable(out_last))
    else $error("result changed while stalled");

  a_stop_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped |-> out_last && !out_write_valid)
    else $error("refused issue is not a single closing transfer");

  a_nowrite_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_stopped)
    else $error("non-write result without stopped");

  a_last_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> (out_last == (out_reg_offset == OFF_COMMAND)))
    else $error("run does not end on the command register");
endmodule

bind ata_verify_sweep_taskfile_gen_unit avs_checker u_avs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_write_valid (out_write_valid),
  .out_reg_offset  (out_reg_offset),
  .out_reg_value   (out_reg_value),
  .out_last        (out_last),
  .out_stopped     (out_stopped)
);
